### hw/rtl/lpl_pkg.sv
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants for the lookahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int MAX_LOOKAHEAD_DEFAULT = 64;
    localparam int SAMPLE_W              = 24;
    localparam int OUT_W                 = 22;
    localparam int CEIL_W                = 23;
    localparam int COEF_W                = 24;
    localparam int LEN_W                 = 7;
    localparam int CFG_IDX_W             = 2;
    localparam int CFG_DATA_W            = 24;
    localparam int QUEUE_DEPTH           = 2;
    localparam int QPTR_W                = 1;
    localparam int DIV_STEPS             = 23;
    localparam int DIV_CNT_W             = 5;
    localparam int PROD_W                = 48;

    localparam logic [COEF_W-1:0] UNITY_Q23 = 24'd8388608;
    localparam logic [PROD_W-1:0] HALF_Q23  = 48'd4194304;
    localparam logic [20:0]       ONE_Q20   = 21'd1048576;

    localparam logic [CEIL_W-1:0] CEILING_RESET = 23'd1048576;
    localparam logic [COEF_W-1:0] ATTACK_RESET  = 24'd8215652;
    localparam logic [COEF_W-1:0] RELEASE_RESET = 24'd8386861;
    localparam logic [LEN_W-1:0]  LENGTH_RESET  = 7'd48;

    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm_sample;
        logic                       last_of_block;
    } sample_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_sample;
        logic                    last_out;
    } result_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] delayed;
        logic                       last;
    } queue_item_t;

    typedef struct packed {
        logic [CEIL_W-1:0] ceiling;
        logic [COEF_W-1:0] attack_coef;
        logic [COEF_W-1:0] release_coef;
        logic [LEN_W-1:0]  lookahead;
    } lpl_cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL_A,
        BK_MUL_B,
        BK_GAIN,
        BK_APPLY,
        BK_EMIT
    } back_state_t;

    function automatic logic [SAMPLE_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] u;
        u = v;
        return v[SAMPLE_W-1] ? (~u + 24'd1) : u;
    endfunction

    function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] c);
        return (c > UNITY_Q23) ? UNITY_Q23 : c;
    endfunction

endpackage

### hw/rtl/lookahead_peak_limiter_unit.sv
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_unit
// Lookahead peak limiter: delays each sample, derives a smoothed gain from
// the incoming peak and applies it to the delayed sample.
//
//   Channel   Signals                                    Direction
//   sample    sample_valid, sample_stall, sample_item    in
//   result    result_valid, result_stall, result_item    out
//   config    cfg_write_enable, cfg_index, cfg_data      in
//
// An item whose magnitude exceeds the ceiling passes through the
// one-bit-per-cycle divider in the back part; other items skip it. The
// front part registers each sample together with its delay ring RAM read.
// Reset restores the register defaults, unity gain and an empty delay ring.
// A stalled result holds the back part; the queue lets the front accept until full.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_unit #(
    parameter int MAX_LOOKAHEAD = lpl_pkg::MAX_LOOKAHEAD_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  lpl_pkg::sample_item_t             sample_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lpl_pkg::result_item_t             result_item,
    input  logic                              cfg_write_enable,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lpl_pkg::*;

    lpl_cfg_t    cfg_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    queue_item_t q_push_item;
    queue_item_t q_pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ceiling      <= CEILING_RESET;
            cfg_reg.attack_coef  <= ATTACK_RESET;
            cfg_reg.release_coef <= RELEASE_RESET;
            cfg_reg.lookahead    <= LENGTH_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_CEILING:   cfg_reg.ceiling      <= cfg_data[CEIL_W-1:0];
                CFG_ATTACK:    cfg_reg.attack_coef  <= cfg_data[COEF_W-1:0];
                CFG_RELEASE:   cfg_reg.release_coef <= cfg_data[COEF_W-1:0];
                CFG_LOOKAHEAD: cfg_reg.lookahead    <= cfg_data[LEN_W-1:0];
                default:       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lpl_front #(
        .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookahead    (cfg_reg.lookahead),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .push         (q_push),
        .push_item    (q_push_item),
        .queue_full   (q_full)
    );

    lpl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    lpl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (q_empty),
        .pop          (q_pop),
        .pop_item     (q_pop_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

### hw/rtl/lpl_ram.sv
// ----------------------------------------------------------------------------
// lpl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lpl_queue.sv
// ----------------------------------------------------------------------------
// lpl_queue
// Short queue between the front and back parts of the limiter.
// ----------------------------------------------------------------------------
module lpl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lpl_pkg::queue_item_t push_item,
    output logic                full,
    input  logic                pop,
    output lpl_pkg::queue_item_t pop_item,
    output logic                empty
);
    import lpl_pkg::*;

    queue_item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg;
    logic [QPTR_W-1:0]        wr_ptr_next;
    logic [QPTR_W-1:0]        rd_ptr_reg;
    logic [QPTR_W-1:0]        rd_ptr_next;
    logic [QPTR_W:0]          count_reg;
    logic [QPTR_W:0]          count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/lpl_front.sv
// ----------------------------------------------------------------------------
// lpl_front
// Accepts samples, runs the lookahead delay ring and hands each sample with
// its delayed partner to the queue.
// ----------------------------------------------------------------------------
module lpl_front #(
    parameter int MAX_LOOKAHEAD = lpl_pkg::MAX_LOOKAHEAD_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [lpl_pkg::LEN_W-1:0] lookahead,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  lpl_pkg::sample_item_t sample_item,
    output logic                 push,
    output lpl_pkg::queue_item_t push_item,
    input  logic                 queue_full
);
    import lpl_pkg::*;

    localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

    logic [AW-1:0]              ring_pos_reg;
    logic [AW-1:0]              ring_pos_next;
    logic [MAX_LOOKAHEAD-1:0]   written_reg;
    logic                       stage_vld_reg;
    logic                       stage_vld_next;
    logic                       stage_hit_reg;
    logic signed [SAMPLE_W-1:0] stage_x_reg;
    logic                       stage_last_reg;
    logic [CW-1:0]              len;
    logic [CW-1:0]              pos_inc;
    logic [AW-1:0]              pos;
    logic                       accept;
    logic [SAMPLE_W-1:0]        ram_rdata;

    always_comb
    begin
        if (lookahead == '0)
        begin
            len = CW'(1);
        end
        else if (int'(lookahead) > MAX_LOOKAHEAD)
        begin
            len = CW'(MAX_LOOKAHEAD);
        end
        else
        begin
            len = CW'(lookahead);
        end
        pos           = (CW'(ring_pos_reg) < len) ? ring_pos_reg : '0;
        pos_inc       = CW'(pos) + CW'(1);
        ring_pos_next = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
    end

    assign push         = stage_vld_reg && !queue_full;
    assign sample_stall = stage_vld_reg && queue_full;
    assign accept       = sample_valid && !sample_stall;
    assign stage_vld_next = accept || (stage_vld_reg && !push);

    assign push_item.sample  = stage_x_reg;
    assign push_item.delayed = stage_hit_reg ? signed'(ram_rdata) : '0;
    assign push_item.last    = stage_last_reg;

    lpl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LOOKAHEAD),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (pos),
        .wdata (sample_item.pcm_sample),
        .re    (accept),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_pos_reg  <= '0;
            written_reg   <= '0;
            stage_vld_reg <= 1'b0;
            stage_hit_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            if (accept)
            begin
                ring_pos_reg     <= ring_pos_next;
                written_reg[pos] <= 1'b1;
                stage_hit_reg    <= written_reg[pos];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_x_reg    <= sample_item.pcm_sample;
            stage_last_reg <= sample_item.last_of_block;
        end
    end

endmodule

### hw/rtl/lpl_back.sv
// ----------------------------------------------------------------------------
// lpl_back
// Computes the target gain with a bit-serial divider, smooths the held gain
// and applies it to the delayed sample.
// ----------------------------------------------------------------------------
module lpl_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpl_pkg::lpl_cfg_t     cfg,
    input  logic                  queue_empty,
    output logic                  pop,
    input  lpl_pkg::queue_item_t  pop_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lpl_pkg::result_item_t result_item
);
    import lpl_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [COEF_W-1:0]      gain_reg;
    logic [COEF_W-1:0]      gain_next;
    logic                   out_vld_reg;
    logic                   out_vld_next;
    result_item_t           out_item_reg;
    result_item_t           out_item_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic [SAMPLE_W-1:0]    mag_reg;
    logic [SAMPLE_W-1:0]    mag_next;
    logic [SAMPLE_W-1:0]    dmag_reg;
    logic [SAMPLE_W-1:0]    dmag_next;
    logic                   dneg_reg;
    logic                   dneg_next;
    logic                   last_reg;
    logic                   last_next;
    logic [CEIL_W-1:0]      rem_reg;
    logic [CEIL_W-1:0]      rem_next;
    logic [COEF_W-1:0]      target_reg;
    logic [COEF_W-1:0]      target_next;
    logic [COEF_W-1:0]      coef_reg;
    logic [COEF_W-1:0]      coef_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic [PROD_W-1:0]      acc_reg;
    logic [PROD_W-1:0]      acc_next;
    logic [SAMPLE_W-1:0]    mag_in;
    logic [SAMPLE_W-1:0]    rem_sh;
    logic                   qbit;
    logic [COEF_W-1:0]      coef_sel;
    logic [COEF_W:0]        gain_full;
    logic [PROD_W:0]        rsum;
    logic [25:0]            rmag_full;
    logic [20:0]            rmag;
    logic [OUT_W-1:0]       ymag;
    logic                   out_free;

    assign result_valid = out_vld_reg;
    assign result_item  = out_item_reg;
    assign out_free     = !out_vld_reg || !result_stall;

    always_comb
    begin
        state_next    = state_reg;
        gain_next     = gain_reg;
        out_vld_next  = out_vld_reg && result_stall;
        out_item_next = out_item_reg;
        cnt_next      = cnt_reg;
        mag_next      = mag_reg;
        dmag_next     = dmag_reg;
        dneg_next     = dneg_reg;
        last_next     = last_reg;
        rem_next      = rem_reg;
        target_next   = target_reg;
        coef_next     = coef_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        pop           = 1'b0;

        mag_in    = abs_sample(pop_item.sample);
        rem_sh    = {rem_reg, 1'b0};
        qbit      = (rem_sh >= mag_reg);
        coef_sel  = sat_coef((target_reg < gain_reg) ? cfg.attack_coef : cfg.release_coef);
        gain_full = acc_reg[PROD_W-1:CEIL_W];
        rsum      = {1'b0, prod_reg} + {1'b0, HALF_Q23};
        rmag_full = rsum[PROD_W:CEIL_W];
        rmag      = (rmag_full > 26'(ONE_Q20)) ? ONE_Q20 : rmag_full[20:0];
        ymag      = {1'b0, rmag};

        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop       = 1'b1;
                    mag_next  = mag_in;
                    dmag_next = abs_sample(pop_item.delayed);
                    dneg_next = pop_item.delayed[SAMPLE_W-1];
                    last_next = pop_item.last;
                    rem_next  = cfg.ceiling;
                    cnt_next  = '0;
                    if (mag_in <= {1'b0, cfg.ceiling})
                    begin
                        target_next = UNITY_Q23;
                        state_next  = BK_MUL_A;
                    end
                    else
                    begin
                        target_next = '0;
                        state_next  = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next    = qbit ? CEIL_W'(rem_sh - mag_reg) : rem_sh[CEIL_W-1:0];
                target_next = {target_reg[COEF_W-2:0], qbit};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = BK_MUL_A;
                end
            end
            BK_MUL_A:
            begin
                coef_next  = coef_sel;
                prod_next  = PROD_W'(coef_sel) * PROD_W'(gain_reg);
                state_next = BK_MUL_B;
            end
            BK_MUL_B:
            begin
                acc_next   = prod_reg + PROD_W'(UNITY_Q23 - coef_reg) * PROD_W'(target_reg)
                             + HALF_Q23;
                state_next = BK_GAIN;
            end
            BK_GAIN:
            begin
                gain_next  = (gain_full > (COEF_W+1)'(UNITY_Q23)) ? UNITY_Q23
                                                                 : gain_full[COEF_W-1:0];
                state_next = BK_APPLY;
            end
            BK_APPLY:
            begin
                prod_next  = PROD_W'(dmag_reg) * PROD_W'(gain_reg);
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next             = 1'b1;
                    out_item_next.out_sample = dneg_reg ? (~ymag + 22'd1) : ymag;
                    out_item_next.last_out   = last_reg;
                    state_next               = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            gain_reg    <= UNITY_Q23;
            out_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            out_vld_reg <= out_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        mag_reg      <= mag_next;
        dmag_reg     <= dmag_next;
        dneg_reg     <= dneg_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
        target_reg   <= target_next;
        coef_reg     <= coef_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
    end

endmodule
